>>> design/brb_pkg.sv
// Shared types and codes for the circular byte FIFO.
package brb_pkg;

    localparam int CNT_W  = 13;
    localparam int OP_W   = 2;
    localparam int LEN_W  = 7;
    localparam int BYTE_W = 8;

    localparam logic [CNT_W-1:0] CAP_RESET = 13'd4096;

    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [LEN_W-1:0]  t_len;
    typedef logic [BYTE_W-1:0] t_byte;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_PEEK  = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_STORED  = 3'd0,
        ST_FULL    = 3'd1,
        ST_NO_CAP  = 3'd2,
        ST_DATA    = 3'd3,
        ST_EMPTY   = 3'd4,
        ST_CLEARED = 3'd5
    } t_status;

    typedef enum logic {
        S_IDLE  = 1'b0,
        S_BURST = 1'b1
    } t_state;

endpackage

>>> design/brb_req_if.sv
// Request channel of the circular byte FIFO.
interface brb_req_if import brb_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  op;
    t_byte            data_byte;
    t_len             request_len;
    logic             final_byte;

    modport source(output valid, output op, output data_byte, output request_len,
                   output final_byte, input ready);
    modport sink(input valid, input op, input data_byte, input request_len,
                 input final_byte, output ready);
endinterface

>>> design/brb_rsp_if.sv
// Result channel of the circular byte FIFO.
interface brb_rsp_if import brb_pkg::*; ();
    logic        valid;
    logic        ready;
    t_byte       byte_out;
    logic [2:0]  status;
    logic        last;
    t_cnt        used_bytes;
    t_cnt        free_bytes;
    t_cnt        contig_read;
    t_cnt        contig_write;

    modport source(output valid, output byte_out, output status, output last,
                   output used_bytes, output free_bytes, output contig_read,
                   output contig_write, input ready);
    modport sink(input valid, input byte_out, input status, input last,
                 input used_bytes, input free_bytes, input contig_read,
                 input contig_write, output ready);
endinterface

>>> design/brb_store.sv
// Byte storage: one write port, one registered read port with read enable.
module brb_store import brb_pkg::*; #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_byte         i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_byte         o_rdata
);

    t_byte mem [DEPTH];
    t_byte r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/byte_ring_buffer.sv
// Circular byte FIFO top level: request sequencer, result stage and output register.
// Write, clear and empty read/peek requests: result via the result stage and output register.
// Read/peek burst of N bytes: accepted, then one byte per cycle from the store read port while
// the result stage is free; no new request is taken until the burst ends.
// Reset: positions zero, capacity 4096, no results pending; store contents undefined,
// no clearing pass. A capacity write empties the buffer.
module byte_ring_buffer import brb_pkg::*; #(
    parameter int DEPTH     = 4096,
    parameter int MAX_BURST = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  t_cnt        i_cfg_wdata,
    brb_req_if.sink     i_req,
    brb_rsp_if.source   o_rsp
);

    localparam int PW  = $clog2(2 * DEPTH);
    localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW  = (PW > CNT_W) ? PW : CNT_W;
    localparam int LXW = (PW > LEN_W) ? PW : LEN_W;

    typedef logic [PW-1:0] t_pos;

    function automatic t_pos f_slot(input t_pos pos, input t_pos cap);
        return (pos >= cap) ? t_pos'(pos - cap) : pos;
    endfunction

    t_state  r_state, n_state;
    t_cnt    r_cap;
    t_pos    r_rd, n_rd, r_wr, n_wr, r_pp, n_pp;
    t_len    r_left, n_left;
    logic    r_is_read, n_is_read;

    logic    r_e_vld;
    t_status r_e_status;
    logic    r_e_last;
    t_pos    r_e_rd, r_e_wr;

    logic    r_o_vld;
    t_byte   r_o_byte;
    t_status r_o_status;
    logic    r_o_last;
    t_cnt    r_o_used, r_o_free, r_o_cr, r_o_cw;

    t_pos    cap_use;
    t_pos    used_now;
    t_len    req_sat, burst_n;
    t_op     req_op;
    logic    req_fire, o_free, e_free;

    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    t_byte         mem_q;

    logic    e_load;
    t_status e_status;
    logic    e_last;
    logic    req_ready;

    t_pos    s_used, s_free, s_rt, s_wt, s_cr, s_cw;

    assign cap_use = (XW'(r_cap) > XW'(DEPTH)) ? t_pos'(DEPTH) : t_pos'(r_cap);
    assign used_now = t_pos'(r_wr - r_rd);
    assign req_op  = t_op'(i_req.op);
    assign req_sat = (i_req.request_len > LEN_W'(MAX_BURST)) ? LEN_W'(MAX_BURST)
                                                              : i_req.request_len;
    assign burst_n = (LXW'(used_now) < LXW'(req_sat)) ? LEN_W'(used_now) : req_sat;

    assign o_free   = !r_o_vld || o_rsp.ready;
    assign e_free   = !r_e_vld || o_free;
    assign req_fire = i_req.valid && req_ready;
    assign i_req.ready = req_ready;

    brb_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (i_req.data_byte),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_q)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (req_fire && (req_op == OP_READ || req_op == OP_PEEK)
                    && burst_n != '0) begin
                    n_state = S_BURST;
                end
            end
            S_BURST: begin
                if (e_free && r_left == LEN_W'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        req_ready = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = AW'(f_slot(r_wr, cap_use));
        mem_raddr = AW'(f_slot(r_is_read ? r_rd : r_pp, cap_use));
        e_load    = 1'b0;
        e_status  = ST_DATA;
        e_last    = 1'b1;
        n_rd      = r_rd;
        n_wr      = r_wr;
        n_pp      = r_pp;
        n_left    = r_left;
        n_is_read = r_is_read;
        unique case (r_state)
            S_IDLE: begin
                req_ready = e_free;
                if (req_fire) begin
                    unique case (req_op) inside
                        OP_WRITE: begin
                            e_load = 1'b1;
                            e_last = i_req.final_byte;
                            if (cap_use == '0) begin
                                e_status = ST_NO_CAP;
                            end else if (used_now >= cap_use) begin
                                e_status = ST_FULL;
                            end else begin
                                e_status = ST_STORED;
                                mem_we   = 1'b1;
                                n_wr     = t_pos'(r_wr + t_pos'(1));
                                if (r_rd >= cap_use && n_wr >= cap_use) begin
                                    n_rd = t_pos'(r_rd - cap_use);
                                    n_wr = t_pos'(n_wr - cap_use);
                                end
                            end
                        end
                        OP_CLEAR: begin
                            e_load   = 1'b1;
                            e_status = ST_CLEARED;
                            n_rd     = '0;
                            n_wr     = '0;
                        end
                        OP_READ, OP_PEEK: begin
                            if (burst_n == '0) begin
                                e_load   = 1'b1;
                                e_status = ST_EMPTY;
                            end else begin
                                n_left    = burst_n;
                                n_pp      = r_rd;
                                n_is_read = (req_op == OP_READ);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_BURST: begin
                if (e_free) begin
                    mem_re   = 1'b1;
                    e_load   = 1'b1;
                    e_status = ST_DATA;
                    e_last   = (r_left == LEN_W'(1));
                    n_left   = t_len'(r_left - LEN_W'(1));
                    if (r_is_read) begin
                        n_rd = t_pos'(r_rd + t_pos'(1));
                        if (n_rd >= cap_use && r_wr >= cap_use) begin
                            n_rd = t_pos'(n_rd - cap_use);
                            n_wr = t_pos'(r_wr - cap_use);
                        end
                    end else begin
                        n_pp = t_pos'(r_pp + t_pos'(1));
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cap     <= CAP_RESET;
            r_rd      <= '0;
            r_wr      <= '0;
            r_pp      <= '0;
            r_left    <= '0;
            r_is_read <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pp      <= n_pp;
            r_left    <= n_left;
            r_is_read <= n_is_read;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
                r_rd  <= '0;
                r_wr  <= '0;
            end else begin
                r_rd <= n_rd;
                r_wr <= n_wr;
            end
        end
    end

    // result stage: snapshot of positions after the update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else if (e_load) begin
            r_e_vld <= 1'b1;
        end else if (o_free) begin
            r_e_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_load) begin
            r_e_status <= e_status;
            r_e_last   <= e_last;
            r_e_rd     <= n_rd;
            r_e_wr     <= n_wr;
        end
    end

    always_comb begin
        s_used = t_pos'(r_e_wr - r_e_rd);
        s_free = t_pos'(cap_use - s_used);
        s_rt   = t_pos'(cap_use - f_slot(r_e_rd, cap_use));
        s_wt   = t_pos'(cap_use - f_slot(r_e_wr, cap_use));
        s_cr   = '0;
        s_cw   = '0;
        if (cap_use != '0) begin
            s_cr = (s_used < s_rt) ? s_used : s_rt;
            s_cw = (s_free < s_wt) ? s_free : s_wt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (o_free) begin
            r_o_vld <= r_e_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && r_e_vld) begin
            r_o_byte   <= (r_e_status == ST_DATA) ? mem_q : '0;
            r_o_status <= r_e_status;
            r_o_last   <= r_e_last;
            r_o_used   <= CNT_W'(s_used);
            r_o_free   <= CNT_W'(s_free);
            r_o_cr     <= CNT_W'(s_cr);
            r_o_cw     <= CNT_W'(s_cw);
        end
    end

    assign o_rsp.valid        = r_o_vld;
    assign o_rsp.byte_out     = r_o_byte;
    assign o_rsp.status       = r_o_status;
    assign o_rsp.last         = r_o_last;
    assign o_rsp.used_bytes   = r_o_used;
    assign o_rsp.free_bytes   = r_o_free;
    assign o_rsp.contig_read  = r_o_cr;
    assign o_rsp.contig_write = r_o_cw;

    a_used_le_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        used_now <= cap_use)
        else $error("bytes held exceed capacity");

    a_rd_below_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cap_use != '0) |-> (r_rd < cap_use))
        else $error("read position not lowered");

    a_burst_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BURST) |-> (r_left != '0))
        else $error("burst with no bytes left");

    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == S_IDLE && req_fire && req_op == OP_WRITE))
        else $error("store write outside a write request");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_e_vld && !o_free) |=> (r_e_vld && $stable(r_e_rd) && $stable(r_e_wr)))
        else $error("result stage overwritten while stalled");

endmodule
